// ===== rtl/rrps_pkg.sv =====
// ----------------------------------------------------------------------------
// rrps_pkg
// Shared types and constants for the round-robin process scheduler: slot
// status codes, action codes and the fixed field widths of the channels.
// ----------------------------------------------------------------------------
package rrps_pkg;

  // Fixed field widths
  localparam int ACTION_W = 2;
  localparam int TICKS_W  = 32;
  localparam int LIMIT_W  = 8;
  localparam int SLOT_W   = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd16;

  // Slot status as stored in the status memory
  typedef enum logic [1:0] {
    ST_DEAD     = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_BLOCKED  = 2'd3
  } status_t;

  // Request actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_SLEEP = 2'd1,
    ACT_EXIT  = 2'd2,
    ACT_FORK  = 2'd3
  } action_t;

endpackage

// ===== rtl/rrps_intf.sv =====
// ----------------------------------------------------------------------------
// rrps channel interfaces
// Valid/ready channels of the scheduler: request beats, response beats and
// the time slice limit write channel.
// ----------------------------------------------------------------------------
interface rrps_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [rrps_pkg::ACTION_W-1:0] action;
  logic [rrps_pkg::TICKS_W-1:0]  sleep_ticks;

  modport source (output valid, action, sleep_ticks, input ready);
  modport sink   (input valid, action, sleep_ticks, output ready);
endinterface

interface rrps_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rrps_pkg::SLOT_W-1:0] current_slot;
  logic                        switched;
  logic                        fork_ok;
  logic [rrps_pkg::SLOT_W-1:0] child_slot;

  modport source (output valid, current_slot, switched, fork_ok, child_slot, input ready);
  modport sink   (input valid, current_slot, switched, fork_ok, child_slot, output ready);
endinterface

interface rrps_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rrps_pkg::LIMIT_W-1:0] time_slice_limit;

  modport source (output valid, time_slice_limit, input ready);
  modport sink   (input valid, time_slice_limit, output ready);
endinterface

// ===== rtl/rrps_ram.sv =====
// ----------------------------------------------------------------------------
// rrps_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module rrps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/round_robin_process_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// round_robin_process_scheduler_core
// Round-robin slot scheduler with a time slice. Slot status and sleep counts
// live in two synchronous memories that one pass per request reads,
// updates and writes back.
// ----------------------------------------------------------------------------
// Sequence: a request is taken only while idle; a sequential pass over the
//   slot memories (one entry read and one written per cycle) follows, and
//   once the output is free the response is registered and idle resumes.
// Reset (rst, synchronous): slot 0 running, all others dead, slice count 0,
//   limit 16. Memory contents read as those values until the first pass
//   has written every entry; no clearing pass is needed.
module round_robin_process_scheduler_core #(
  parameter int SLOTS = 8
) (
  input logic        clk,
  input logic        rst,
  rrps_cfg_if.sink   cfg,
  rrps_cmd_if.sink   cmd,
  rrps_rsp_if.source rsp
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} fsm_t;

  fsm_t                              state;
  logic [rrps_pkg::LIMIT_W-1:0]      limit;
  logic [AW-1:0]                     cur;
  logic [rrps_pkg::LIMIT_W-1:0]      slice;
  logic                              filled;
  rrps_pkg::action_t                 act;
  logic [rrps_pkg::TICKS_W-1:0]      ticks;
  logic [CW-1:0]                     rd_idx;
  logic                              pvld;
  logic [AW-1:0]                     pidx;
  logic                              hi_found;
  logic [AW-1:0]                     hi_idx;
  logic                              lo_found;
  logic [AW-1:0]                     lo_idx;
  logic                              fk_found;
  logic [AW-1:0]                     fk_idx;
  logic                              rsp_valid;
  logic [rrps_pkg::SLOT_W-1:0]       rsp_cur;
  logic                              rsp_sw;
  logic                              rsp_fok;
  logic [rrps_pkg::SLOT_W-1:0]       rsp_child;

  // Memory ports
  logic                         st_we;
  logic [AW-1:0]                st_waddr;
  logic [1:0]                   st_wdata;
  logic [1:0]                   st_rdata;
  logic                         cnt_we;
  logic [rrps_pkg::TICKS_W-1:0] cnt_rdata;
  logic                         rd_en;

  // Per-entry update
  rrps_pkg::status_t            st_in;
  rrps_pkg::status_t            st_mod;
  logic [rrps_pkg::TICKS_W-1:0] cnt_in;
  logic [rrps_pkg::TICKS_W-1:0] cnt_mod;
  logic                         take_child;
  logic                         preempt;
  logic                         do_sel;
  logic [AW-1:0]                next_idx;
  logic [AW-1:0]                chosen;
  logic                         out_free;
  logic                         finish_go;

  rrps_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_status_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (rd_en),
    .raddr (rd_idx[AW-1:0]),
    .rdata (st_rdata)
  );

  rrps_ram #(.WIDTH(rrps_pkg::TICKS_W), .DEPTH(SLOTS)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (pidx),
    .wdata (cnt_mod),
    .re    (rd_en),
    .raddr (rd_idx[AW-1:0]),
    .rdata (cnt_rdata)
  );

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == S_IDLE);

  assign rsp.valid        = rsp_valid;
  assign rsp.current_slot = rsp_cur;
  assign rsp.switched     = rsp_sw;
  assign rsp.fork_ok      = rsp_fok;
  assign rsp.child_slot   = rsp_child;

  assign rd_en     = (state == S_SCAN) && (rd_idx < CW'(SLOTS));
  assign preempt   = (slice >= limit);
  assign do_sel    = ((act == rrps_pkg::ACT_TICK) && preempt) ||
                     (act == rrps_pkg::ACT_SLEEP) || (act == rrps_pkg::ACT_EXIT);
  assign next_idx  = (cur == LAST) ? '0 : cur + 1'b1;
  assign chosen    = hi_found ? hi_idx : (lo_found ? lo_idx : next_idx);
  assign out_free  = !rsp_valid || rsp.ready;
  assign finish_go = (state == S_FINISH) && out_free;

  // Take the reset contents until the first pass has written every entry
  always_comb begin
    if (filled) begin
      st_in  = rrps_pkg::status_t'(st_rdata);
      cnt_in = cnt_rdata;
    end else begin
      st_in  = (pidx == '0) ? rrps_pkg::ST_RUNNING : rrps_pkg::ST_DEAD;
      cnt_in = '0;
    end
  end

  // Modify one entry for the current action
  always_comb begin
    st_mod     = st_in;
    cnt_mod    = cnt_in;
    take_child = 1'b0;
    case (act)
      rrps_pkg::ACT_TICK: begin
        if ((st_in == rrps_pkg::ST_BLOCKED) && (cnt_in != '0)) begin
          cnt_mod = cnt_in - 1'b1;
          if (cnt_mod == '0) begin
            st_mod = rrps_pkg::ST_RUNNABLE;
          end
        end
        if (preempt && (pidx == cur)) begin
          st_mod = rrps_pkg::ST_RUNNABLE;
        end
      end
      rrps_pkg::ACT_SLEEP: begin
        if (pidx == cur) begin
          st_mod  = rrps_pkg::ST_BLOCKED;
          cnt_mod = ticks;
        end
      end
      rrps_pkg::ACT_EXIT: begin
        if (pidx == cur) begin
          st_mod = rrps_pkg::ST_DEAD;
        end
      end
      rrps_pkg::ACT_FORK: begin
        if ((st_in == rrps_pkg::ST_DEAD) && !fk_found) begin
          take_child = 1'b1;
          st_mod     = rrps_pkg::ST_RUNNABLE;
          cnt_mod    = '0;
        end
      end
      default: begin
        st_mod = st_in;
      end
    endcase
  end

  // Status write port: write back during the pass, then at most one status update
  always_comb begin
    cnt_we   = (state == S_SCAN) && pvld;
    st_we    = cnt_we;
    st_waddr = pidx;
    st_wdata = st_mod;
    if (finish_go) begin
      if (do_sel) begin
        st_we    = 1'b1;
        st_waddr = chosen;
        st_wdata = rrps_pkg::ST_RUNNING;
      end else if ((act == rrps_pkg::ACT_FORK) && fk_found) begin
        st_we    = 1'b1;
        st_waddr = cur;
        st_wdata = rrps_pkg::ST_RUNNABLE;
      end
    end
  end

  // Sequencer, scheduler registers and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      limit     <= rrps_pkg::LIMIT_RESET;
      cur       <= '0;
      slice     <= '0;
      filled    <= 1'b0;
      pvld      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        limit <= cfg.time_slice_limit;
      end
      if (rsp.ready && !finish_go) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            act      <= rrps_pkg::action_t'(cmd.action);
            ticks    <= cmd.sleep_ticks;
            rd_idx   <= '0;
            pvld     <= 1'b0;
            hi_found <= 1'b0;
            lo_found <= 1'b0;
            fk_found <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Advance the read pointer, trail it by one with the update
          if (rd_en) begin
            rd_idx <= rd_idx + 1'b1;
          end
          pvld <= rd_en;
          pidx <= rd_idx[AW-1:0];
          if (pvld) begin
            if (st_mod == rrps_pkg::ST_RUNNABLE) begin
              if ((pidx > cur) && !hi_found) begin
                hi_found <= 1'b1;
                hi_idx   <= pidx;
              end
              if ((pidx <= cur) && !lo_found) begin
                lo_found <= 1'b1;
                lo_idx   <= pidx;
              end
            end
            if (take_child) begin
              fk_found <= 1'b1;
              fk_idx   <= pidx;
            end
            if (pidx == LAST) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          // Hold until the response register is free
          if (out_free) begin
            filled  <= 1'b1;
            rsp_sw  <= do_sel;
            rsp_fok <= (act == rrps_pkg::ACT_FORK) && fk_found;
            rsp_child <= ((act == rrps_pkg::ACT_FORK) && fk_found) ?
                         rrps_pkg::SLOT_W'(fk_idx) : '0;
            rsp_valid <= 1'b1;
            if (do_sel) begin
              cur     <= chosen;
              slice   <= '0;
              rsp_cur <= rrps_pkg::SLOT_W'(chosen);
            end else begin
              rsp_cur <= rrps_pkg::SLOT_W'(cur);
              if (act == rrps_pkg::ACT_TICK) begin
                slice <= slice + 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/rrps_checker.sv =====
// ----------------------------------------------------------------------------
// rrps_checker
// Port-level checks of the scheduler core, bound to the core module.
// ----------------------------------------------------------------------------
module rrps_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_valid,
  input logic                        cmd_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [rrps_pkg::SLOT_W-1:0] rsp_current_slot,
  input logic                        rsp_switched,
  input logic                        rsp_fork_ok,
  input logic [rrps_pkg::SLOT_W-1:0] rsp_child_slot
);

  // No response right after reset
  a_rst_quiet: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

  // A fork never reschedules
  a_fork_no_switch: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_fork_ok |-> !rsp_switched)
    else $error("fork reported a switch");

  // Child slot is zero unless a fork succeeded
  a_child_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_fork_ok |-> (rsp_child_slot == '0))
    else $error("child slot set without a successful fork");

  // One request in flight: no request taken in the cycle after a beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("request taken back to back");

  // Stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_slot) &&
      $stable(rsp_switched) && $stable(rsp_fork_ok) && $stable(rsp_child_slot))
    else $error("stalled response changed");

endmodule

bind round_robin_process_scheduler_core rrps_checker u_rrps_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_current_slot (rsp.current_slot),
  .rsp_switched     (rsp.switched),
  .rsp_fork_ok      (rsp.fork_ok),
  .rsp_child_slot   (rsp.child_slot)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for round_robin_process_scheduler_core. A short table
// of request beats walks the slot table through forks, sleeps, exits and a
// failed fork. Random request streams then run under several time slice
// limits. Each request is mirrored by a slot table model in the bench, and
// every response beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import rrps_pkg::*;

  localparam int SLOTS       = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 96;
  localparam int DIR_ROWS    = 25;

  typedef struct packed {
    logic [SLOT_W-1:0] current_slot;
    logic              switched;
    logic              fork_ok;
    logic [SLOT_W-1:0] child_slot;
  } sched_rsp_t;

  // One directed request; known marks rows whose response is typed in
  typedef struct packed {
    action_t          act;
    logic [TICKS_W-1:0] ticks;
    logic             known;
    sched_rsp_t       rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  rrps_cfg_if cfg ();
  rrps_cmd_if cmd ();
  rrps_rsp_if rsp ();

  round_robin_process_scheduler_core #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .cmd(cmd),
    .rsp(rsp)
  );

  // Slot table model
  status_t            slot_state [SLOTS];
  logic [TICKS_W-1:0] sleep_left [SLOTS];
  logic [SLOT_W-1:0]  run_slot;
  logic [LIMIT_W-1:0] slice_used;
  logic [LIMIT_W-1:0] slice_limit;

  sched_rsp_t rsp_due [$];
  sched_rsp_t rsp_want;
  int         mismatch_count = 0;
  int         cycle_count = 0;
  logic       steady = 1'b0;

  // Walk through the table: forks up to a full table, sleeps of zero, one
  // and all ones, exits down to nothing runnable, then recovery
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ACT_FORK,  32'h0000_0000, 1'b1, {3'd0, 1'b0, 1'b1, 3'd1}},
    '{ACT_TICK,  32'hFFFF_FFFF, 1'b1, {3'd0, 1'b0, 1'b0, 3'd0}},
    '{ACT_SLEEP, 32'h0000_0000, 1'b1, {3'd1, 1'b1, 1'b0, 3'd0}},
    '{ACT_FORK,  32'h0000_0000, 1'b1, {3'd1, 1'b0, 1'b1, 3'd2}},
    '{ACT_SLEEP, 32'h0000_0003, 1'b1, {3'd2, 1'b1, 1'b0, 3'd0}},
    '{ACT_FORK,  32'h0000_0000, 1'b1, {3'd2, 1'b0, 1'b1, 3'd3}},
    '{ACT_FORK,  32'h0000_0000, 1'b1, {3'd2, 1'b0, 1'b1, 3'd4}},
    '{ACT_FORK,  32'h0000_0000, 1'b1, {3'd2, 1'b0, 1'b1, 3'd5}},
    '{ACT_FORK,  32'h0000_0000, 1'b1, {3'd2, 1'b0, 1'b1, 3'd6}},
    '{ACT_FORK,  32'h0000_0000, 1'b1, {3'd2, 1'b0, 1'b1, 3'd7}},
    '{ACT_FORK,  32'hFFFF_FFFF, 1'b1, {3'd2, 1'b0, 1'b0, 3'd0}},
    '{ACT_EXIT,  32'hFFFF_FFFF, 1'b1, {3'd3, 1'b1, 1'b0, 3'd0}},
    '{ACT_SLEEP, 32'h0000_0001, 1'b0, '0},
    '{ACT_TICK,  32'h0000_0000, 1'b0, '0},
    '{ACT_TICK,  32'hA5A5_5A5A, 1'b0, '0},
    '{ACT_EXIT,  32'h0000_0000, 1'b0, '0},
    '{ACT_EXIT,  32'h5A5A_A5A5, 1'b0, '0},
    '{ACT_EXIT,  32'h0000_0000, 1'b0, '0},
    '{ACT_EXIT,  32'h0000_0000, 1'b0, '0},
    '{ACT_EXIT,  32'h0000_0000, 1'b0, '0},
    '{ACT_TICK,  32'h0000_0000, 1'b0, '0},
    '{ACT_SLEEP, 32'hFFFF_FFFF, 1'b0, '0},
    '{ACT_FORK,  32'h0000_0000, 1'b0, '0},
    '{ACT_SLEEP, 32'h0000_0002, 1'b0, '0},
    '{ACT_EXIT,  32'h0000_0000, 1'b0, '0}
  };

  logic [LIMIT_W-1:0] phase_limit [PHASES] = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd0, 8'd2};

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void sched_reset();
    for (int k = 0; k < SLOTS; k++) begin
      slot_state[k] = ST_DEAD;
      sleep_left[k] = '0;
    end
    slot_state[0] = ST_RUNNING;
    run_slot      = '0;
    slice_used    = '0;
    slice_limit   = LIMIT_RESET;
  endfunction

  // Round-robin search after the current slot; fall back to the next index
  function automatic void select_next();
    int start_idx;
    int s;
    start_idx = (int'(run_slot) + 1) % SLOTS;
    run_slot  = SLOT_W'(start_idx);
    for (int k = SLOTS - 1; k >= 0; k--) begin
      s = (start_idx + k) % SLOTS;
      if (slot_state[s] == ST_RUNNABLE) run_slot = SLOT_W'(s);
    end
    slot_state[run_slot] = ST_RUNNING;
    slice_used = '0;
  endfunction

  // Apply one request to the slot table and return its response
  function automatic sched_rsp_t sched_step(action_t act, logic [TICKS_W-1:0] ticks);
    sched_rsp_t r;
    int         cur;
    int         child;
    r     = '0;
    cur   = int'(run_slot);
    child = -1;
    case (act)
      ACT_TICK: begin
        for (int k = 0; k < SLOTS; k++) begin
          if (sleep_left[k] != 0 && slot_state[k] == ST_BLOCKED) begin
            sleep_left[k] = sleep_left[k] - 1;
            if (sleep_left[k] == 0) slot_state[k] = ST_RUNNABLE;
          end
        end
        if (slice_used < slice_limit) begin
          slice_used = slice_used + 1'b1;
        end else begin
          slot_state[cur] = ST_RUNNABLE;
          select_next();
          r.switched = 1'b1;
        end
      end
      ACT_SLEEP: begin
        sleep_left[cur] = ticks;
        slot_state[cur] = ST_BLOCKED;
        select_next();
        r.switched = 1'b1;
      end
      ACT_EXIT: begin
        slot_state[cur] = ST_DEAD;
        select_next();
        r.switched = 1'b1;
      end
      default: begin
        // Claim the lowest dead slot
        for (int k = SLOTS - 1; k >= 0; k--) begin
          if (slot_state[k] == ST_DEAD) child = k;
        end
        if (child >= 0) begin
          slot_state[child] = ST_RUNNABLE;
          sleep_left[child] = '0;
          slot_state[cur]   = ST_RUNNABLE;
          r.fork_ok    = 1'b1;
          r.child_slot = SLOT_W'(child);
        end
      end
    endcase
    r.current_slot = run_slot;
    return r;
  endfunction

  // Drive one request beat; called and returns at a falling edge
  task automatic send_req(action_t act, logic [TICKS_W-1:0] ticks, logic known,
                          sched_rsp_t known_rsp);
    sched_rsp_t pred;
    while (!steady && $urandom_range(0, 99) < 36) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.action      <= act;
    cmd.sleep_ticks <= ticks;
    do @(posedge clk); while (!cmd.ready);
    pred = sched_step(act, ticks);
    rsp_due.push_back(known ? known_rsp : pred);
    @(negedge clk);
  endtask

  // Hold requests until every predicted response has come back
  task automatic drain_results();
    cmd.valid <= 1'b0;
    do @(negedge clk); while (rsp_due.size() != 0);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] lim);
    drain_results();
    cfg.valid            <= 1'b1;
    cfg.time_slice_limit <= lim;
    do @(posedge clk); while (!cfg.ready);
    slice_limit = lim;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic void random_req(output action_t act, output logic [TICKS_W-1:0] ticks);
    int roll;
    int len_roll;
    roll     = $urandom_range(0, 99);
    len_roll = $urandom_range(0, 99);
    ticks    = $urandom;
    if (roll < 50) begin
      act = ACT_TICK;
    end else if (roll < 70) begin
      act = ACT_SLEEP;
      // Mostly short sleeps so sleepers wake; a few that never do
      if (len_roll < 80) ticks = $urandom_range(0, 6);
      else if (len_roll < 90) ticks = $urandom_range(7, 40);
      else if (len_roll < 95) ticks = 32'hFFFF_FFFF;
    end else if (roll < 82) begin
      act = ACT_EXIT;
    end else begin
      act = ACT_FORK;
    end
  endfunction

  // Response side: stall at random except during the steady phase
  always @(negedge clk) begin
    rsp.ready <= steady || ($urandom_range(0, 99) >= 36);
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each response beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (rsp_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none got slot %0d", $time,
                 rsp.current_slot);
        mismatch_count++;
      end else begin
        rsp_want = rsp_due.pop_front();
        check_field("current_slot", int'(rsp_want.current_slot),
                    int'(rsp.current_slot));
        check_field("switched", int'(rsp_want.switched), int'(rsp.switched));
        check_field("fork_ok", int'(rsp_want.fork_ok), int'(rsp.fork_ok));
        check_field("child_slot", int'(rsp_want.child_slot), int'(rsp.child_slot));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("round_robin_process_scheduler_core: mismatch");
      $finish;
    end
  end

  initial begin
    action_t            act;
    logic [TICKS_W-1:0] ticks;
    logic [LIMIT_W-1:0] lim;
    rst                  = 1'b1;
    cmd.valid            = 1'b0;
    cmd.action           = ACT_TICK;
    cmd.sleep_ticks      = '0;
    cfg.valid            = 1'b0;
    cfg.time_slice_limit = '0;
    rsp.ready            = 1'b0;
    sched_reset();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table at the reset limit
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_req(dir_tab[i].act, dir_tab[i].ticks, dir_tab[i].known, dir_tab[i].rsp);
    end

    // Random streams, one limit per phase
    for (int p = 0; p < PHASES; p++) begin
      lim = (p == PHASES - 1) ? LIMIT_W'($urandom_range(4, 254)) : phase_limit[p];
      write_limit(lim);
      steady = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == PHASE_ITEMS / 2) drain_results();
        random_req(act, ticks);
        send_req(act, ticks, 1'b0, '0);
      end
      steady = 1'b0;
    end

    // Wait out the last responses and any stray beat
    cmd.valid <= 1'b0;
    while (rsp_due.size() != 0) @(negedge clk);
    repeat (SLOTS + 4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("round_robin_process_scheduler_core: match");
    end else begin
      $display("round_robin_process_scheduler_core: mismatch");
    end
    $finish;
  end

endmodule
